// ===== rtl/obmi_pkg.sv =====
// Package for the omni base motion integrator: sequencer codes, register
// indexes, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`default_nettype none

package obmi_pkg;

   localparam int BASE_RADIUS       = 16384;
   localparam int CORDIC_ITERATIONS = 16;

   localparam logic [15:0]        AGE_LIMIT = 16'd6553;
   localparam logic [15:0]        AGE_MAX   = 16'hFFFF;
   localparam logic signed [33:0] GAIN_Q30  = 34'sd652032875;
   localparam logic [39:0]        SPIN_K    = 40'(64'(BASE_RADIUS) * 64'd411775);

   localparam logic [22:0] RST_MAX_SPEED  = 23'd131072;
   localparam logic [22:0] RST_MAX_ACCEL  = 23'd196608;
   localparam logic [22:0] RST_MAX_TURN   = 23'd32768;
   localparam logic [22:0] RST_TURN_ACCEL = 23'd65536;
   localparam logic [15:0] RST_WHEEL_A    = 16'h0000;
   localparam logic [15:0] RST_WHEEL_B    = 16'h4000;
   localparam logic [15:0] RST_WHEEL_C    = 16'h8000;
   localparam logic [15:0] RST_WHEEL_D    = 16'hC000;

   typedef enum logic [2:0] {
      CSR_MAX_SPEED,
      CSR_MAX_ACCEL,
      CSR_MAX_TURN,
      CSR_TURN_ACCEL,
      CSR_WHEEL_A,
      CSR_WHEEL_B,
      CSR_WHEEL_C,
      CSR_WHEEL_D
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_BUSY,
      S_WB,
      S_FIN
   } seq_state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_MUL,
      OP_DIV,
      OP_SQRT,
      OP_CORDIC
   } op_type;

   typedef enum logic [4:0] {
      ST_SQ_X, ST_SQ_Y, ST_SQ_L, ST_ROOT,
      ST_MUL_X, ST_DIV_X, ST_MUL_Y, ST_DIV_Y,
      ST_MA, ST_MRA, ST_VR, ST_HROT,
      ST_RX1, ST_RX2, ST_RY1, ST_RY2,
      ST_PX, ST_PY, ST_PH, ST_SPIN,
      ST_WROT, ST_W1, ST_W2
   } step_type;

   // atan(2^-i) in 2^-32 turn
   function automatic logic signed [32:0] atan_entry(input logic [4:0] idx);
      logic signed [32:0] v;
      begin
         case (idx)
            5'd0:    v = 33'sh020000000;
            5'd1:    v = 33'sh012E4051D;
            5'd2:    v = 33'sh009FB385B;
            5'd3:    v = 33'sh0051111D4;
            5'd4:    v = 33'sh0028B0D43;
            5'd5:    v = 33'sh00145D7E1;
            5'd6:    v = 33'sh000A2F61E;
            5'd7:    v = 33'sh000517C55;
            5'd8:    v = 33'sh00028BE53;
            5'd9:    v = 33'sh000145F2E;
            5'd10:   v = 33'sh0000A2F98;
            5'd11:   v = 33'sh0000517CC;
            5'd12:   v = 33'sh000028BE6;
            5'd13:   v = 33'sh0000145F3;
            5'd14:   v = 33'sh000000A2F9;
            5'd15:   v = 33'sh00000517C;
            5'd16:   v = 33'sh0000028BE;
            5'd17:   v = 33'sh00000145F;
            5'd18:   v = 33'sh000000A2F;
            5'd19:   v = 33'sh000000517;
            5'd20:   v = 33'sh00000028B;
            5'd21:   v = 33'sh000000145;
            5'd22:   v = 33'sh0000000A2;
            5'd23:   v = 33'sh000000051;
            default: v = 33'sh000000000;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/omni_base_motion_integrator.sv =====
// Omni base motion integrator: command latch, speed/accel limiting, pose
// integration and wheel speeds, run by a step sequencer over serial units.
// Depends on obmi_pkg.
//
// Channel  Dir  Transfer when          Payload
// req      in   req_tvalid&req_tready  tuser kind; tdata cmd_vx,cmd_vy,cmd_vr,step_time
// rsp      out  rsp_tvalid&rsp_tready  tdata pose, body velocity, four wheel speeds
// csr      in   csr_we                 csr_addr register index, csr_wdata value
//
// A command gives no result. A tick runs 24 to 28 bit-serial products,
// plus five 16-step CORDIC runs and up to two 26-step roots and four 48-step
// divides. Synchronous reset restores the register defaults and zeroes the
// motion state. A finished result waits in the output register; the next
// item is taken meanwhile and its result waits until that one is taken.
`default_nettype none

module omni_base_motion_integrator
   import obmi_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [87:0]  req_tdata,  // cmd_vx, cmd_vy, cmd_vr, step_time
   input  wire logic         req_tuser,  // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [255:0]      rsp_tdata,  // pos_x, pos_y, heading_out, vel_x_out,
                                         // vel_y_out, turn_rate_out, wheel_speed_a..d
   input  wire logic         csr_we,
   input  wire logic [2:0]   csr_addr,
   input  wire logic [22:0]  csr_wdata
);

   // configuration
   logic [22:0]        max_speed_ff, max_speed_in, max_accel_ff, max_accel_in;
   logic [22:0]        max_turn_ff, max_turn_in, turn_accel_ff, turn_accel_in;
   logic signed [15:0] wang_ff [4];
   logic signed [15:0] wang_in [4];

   // motion state
   logic signed [23:0] tgt_vx_ff, tgt_vx_in, tgt_vy_ff, tgt_vy_in, tgt_vr_ff, tgt_vr_in;
   logic [15:0]        age_ff, age_in;
   logic signed [23:0] bvx_ff, bvx_in, bvy_ff, bvy_in, bvr_ff, bvr_in;
   logic signed [31:0] posx_ff, posx_in, posy_ff, posy_in;
   logic signed [15:0] hdg_ff, hdg_in;

   // sequencer
   seq_state_type st_ff, st_in;
   step_type      pc_ff, pc_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic          ph_ff, ph_in;
   logic [1:0]    k_ff, k_in;

   // working registers
   logic [15:0]        dt_ff, dt_in;
   logic signed [25:0] dvx_ff, dvx_in, dvy_ff, dvy_in;
   logic [22:0]        lim_ff, lim_in;
   logic signed [67:0] acc_ff, acc_in;
   logic [25:0]        r_ff, r_in;
   logic signed [31:0] c_ff, c_in, s_ff, s_in;
   logic signed [25:0] er_ff, er_in;
   logic signed [25:0] wvx_ff, wvx_in, wvy_ff, wvy_in;
   logic signed [33:0] spin_ff, spin_in;
   logic signed [24:0] wspd_ff [4];
   logic signed [24:0] wspd_in [4];

   // serial units
   logic signed [67:0] ma_ff, ma_in, mp_ff, mp_in;
   logic signed [25:0] mb_ff, mb_in;
   logic [47:0]        dnum_ff, dnum_in;
   logic [25:0]        drem_ff, drem_in;
   logic [51:0]        snum_ff, snum_in;
   logic [26:0]        srem_ff, srem_in;
   logic [25:0]        sroot_ff, sroot_in;
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [32:0] cz_ff, cz_in;
   logic               cqp_ff, cqp_in, cqn_ff, cqn_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [255:0]       rsp_data_ff, rsp_data_in;

   // combinational
   op_type             op;
   logic signed [41:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [15:0] cor_ang;
   logic [5:0]         last_cnt;
   logic               req_acc, tick_acc, cmd_acc, stale;
   logic [16:0]        age_sum;
   logic signed [25:0] dvx_mag, dvy_mag, dt_s;
   logic [26:0]        drsh;
   logic               dge;
   logic [28:0]        srsh, strial;
   logic               sge;
   logic signed [33:0] cxs, cys;
   logic signed [32:0] cat;
   logic signed [67:0] sum_sub, sum_add, rnd_sub30, rnd_add30, p16, p32;
   logic signed [31:0] cor_c, cor_s;
   logic signed [24:0] tv25, mtr25, drc;
   logic signed [25:0] lim26, erc, qs;
   logic signed [33:0] pos_t;
   logic signed [35:0] whl_t;
   logic signed [24:0] whl_sat;
   logic signed [15:0] ang_adj;

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign req_acc  = req_tvalid && req_tready;
   assign tick_acc = req_acc && req_tuser;
   assign cmd_acc  = req_acc && !req_tuser;
   assign stale    = (age_ff > AGE_LIMIT);
   assign age_sum  = {1'b0, age_ff} + {1'b0, req_tdata[87:72]};

   assign dvx_mag = dvx_ff[25] ? -dvx_ff : dvx_ff;
   assign dvy_mag = dvy_ff[25] ? -dvy_ff : dvy_ff;
   assign dt_s    = signed'({10'd0, dt_ff});

   // step decoder
   always_comb begin
      op      = OP_NONE;
      mul_a   = '0;
      mul_b   = '0;
      cor_ang = hdg_ff;
      unique case (pc_ff)
         ST_SQ_X:  begin op = OP_MUL; mul_a = 42'(dvx_ff); mul_b = dvx_ff; end
         ST_SQ_Y:  begin op = OP_MUL; mul_a = 42'(dvy_ff); mul_b = dvy_ff; end
         ST_SQ_L:  begin
            op = OP_MUL; mul_a = signed'({19'd0, lim_ff}); mul_b = signed'({3'd0, lim_ff});
         end
         ST_ROOT:  op = OP_SQRT;
         ST_MUL_X: begin op = OP_MUL; mul_a = signed'({19'd0, lim_ff}); mul_b = dvx_mag; end
         ST_DIV_X: op = OP_DIV;
         ST_MUL_Y: begin op = OP_MUL; mul_a = signed'({19'd0, lim_ff}); mul_b = dvy_mag; end
         ST_DIV_Y: op = OP_DIV;
         ST_MA:    begin op = OP_MUL; mul_a = signed'({19'd0, max_accel_ff}); mul_b = dt_s; end
         ST_MRA:   begin op = OP_MUL; mul_a = signed'({19'd0, turn_accel_ff}); mul_b = dt_s; end
         ST_VR:    op = OP_NONE;
         ST_HROT:  begin op = OP_CORDIC; cor_ang = hdg_ff; end
         ST_RX1:   begin op = OP_MUL; mul_a = 42'(c_ff); mul_b = 26'(bvx_ff); end
         ST_RX2:   begin op = OP_MUL; mul_a = 42'(s_ff); mul_b = 26'(bvy_ff); end
         ST_RY1:   begin op = OP_MUL; mul_a = 42'(s_ff); mul_b = 26'(bvx_ff); end
         ST_RY2:   begin op = OP_MUL; mul_a = 42'(c_ff); mul_b = 26'(bvy_ff); end
         ST_PX:    begin op = OP_MUL; mul_a = 42'(wvx_ff); mul_b = dt_s; end
         ST_PY:    begin op = OP_MUL; mul_a = 42'(wvy_ff); mul_b = dt_s; end
         ST_PH:    begin op = OP_MUL; mul_a = 42'(bvr_ff); mul_b = dt_s; end
         ST_SPIN:  begin op = OP_MUL; mul_a = signed'({2'd0, SPIN_K}); mul_b = 26'(bvr_ff); end
         ST_WROT:  begin op = OP_CORDIC; cor_ang = wang_ff[k_ff]; end
         ST_W1:    begin op = OP_MUL; mul_a = 42'(c_ff); mul_b = 26'(bvx_ff); end
         ST_W2:    begin op = OP_MUL; mul_a = 42'(s_ff); mul_b = 26'(bvy_ff); end
         default:  op = OP_NONE;
      endcase
   end

   always_comb begin
      unique case (op)
         OP_DIV:    last_cnt = 6'd47;
         OP_CORDIC: last_cnt = 6'(CORDIC_ITERATIONS - 1);
         default:   last_cnt = 6'd25;
      endcase
   end

   // unit datapaths
   assign drsh   = {drem_ff, dnum_ff[47]};
   assign dge    = (drsh >= {1'b0, r_ff});
   assign srsh   = {srem_ff, snum_ff[51:50]};
   assign strial = {1'b0, sroot_ff, 2'b01};
   assign sge    = (srsh >= strial);
   assign cxs    = cx_ff >>> cnt_ff[4:0];
   assign cys    = cy_ff >>> cnt_ff[4:0];
   assign cat    = atan_entry(cnt_ff[4:0]);
   assign ang_adj = (cor_ang > 16'sd16384)  ? cor_ang - 16'sd16384 :
                    (cor_ang < -16'sd16384) ? cor_ang + 16'sd16384 : cor_ang;

   // writeback arithmetic
   assign sum_sub   = acc_ff - mp_ff;
   assign sum_add   = acc_ff + mp_ff;
   assign rnd_sub30 = (sum_sub + 68'sd536870912) >>> 30;
   assign rnd_add30 = (sum_add + 68'sd536870912) >>> 30;
   assign p16       = (mp_ff + 68'sd32768) >>> 16;
   assign p32       = (mp_ff + 68'sd2147483648) >>> 32;
   assign cor_c     = cqp_ff ? 32'(-cy_ff) : (cqn_ff ? 32'(cy_ff) : 32'(cx_ff));
   assign cor_s     = cqp_ff ? 32'(cx_ff) : (cqn_ff ? 32'(-cx_ff) : 32'(cy_ff));
   assign tv25      = 25'(tgt_vr_ff);
   assign mtr25     = signed'({2'd0, max_turn_ff});
   assign drc       = (tv25 > mtr25) ? mtr25 : ((tv25 < -mtr25) ? -mtr25 : tv25);
   assign lim26     = signed'({3'd0, lim_ff});
   assign erc       = (er_ff > lim26) ? lim26 : ((er_ff < -lim26) ? -lim26 : er_ff);
   assign qs        = signed'({2'd0, dnum_ff[23:0]});
   assign pos_t     = (pc_ff == ST_PX ? 34'(posx_ff) : 34'(posy_ff)) + 34'(p16);
   assign whl_t     = 36'(rnd_add30) + 36'(spin_ff);
   assign whl_sat   = (whl_t > 36'sd16777215) ? 25'sd16777215 :
                      ((whl_t < -36'sd16777216) ? -25'sd16777216 : 25'(whl_t));

   always_comb begin
      max_speed_in  = max_speed_ff;
      max_accel_in  = max_accel_ff;
      max_turn_in   = max_turn_ff;
      turn_accel_in = turn_accel_ff;
      wang_in       = wang_ff;
      tgt_vx_in = tgt_vx_ff; tgt_vy_in = tgt_vy_ff; tgt_vr_in = tgt_vr_ff;
      age_in    = age_ff;
      bvx_in = bvx_ff; bvy_in = bvy_ff; bvr_in = bvr_ff;
      posx_in = posx_ff; posy_in = posy_ff; hdg_in = hdg_ff;
      st_in = st_ff; pc_in = pc_ff; cnt_in = cnt_ff; ph_in = ph_ff; k_in = k_ff;
      dt_in = dt_ff; dvx_in = dvx_ff; dvy_in = dvy_ff; lim_in = lim_ff;
      acc_in = acc_ff; r_in = r_ff; c_in = c_ff; s_in = s_ff; er_in = er_ff;
      wvx_in = wvx_ff; wvy_in = wvy_ff; spin_in = spin_ff; wspd_in = wspd_ff;
      ma_in = ma_ff; mp_in = mp_ff; mb_in = mb_ff;
      dnum_in = dnum_ff; drem_in = drem_ff;
      snum_in = snum_ff; srem_in = srem_ff; sroot_in = sroot_ff;
      cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; cqp_in = cqp_ff; cqn_in = cqn_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_MAX_SPEED:  max_speed_in  = csr_wdata;
            CSR_MAX_ACCEL:  max_accel_in  = csr_wdata;
            CSR_MAX_TURN:   max_turn_in   = csr_wdata;
            CSR_TURN_ACCEL: turn_accel_in = csr_wdata;
            CSR_WHEEL_A:    wang_in[0] = signed'(csr_wdata[15:0]);
            CSR_WHEEL_B:    wang_in[1] = signed'(csr_wdata[15:0]);
            CSR_WHEEL_C:    wang_in[2] = signed'(csr_wdata[15:0]);
            CSR_WHEEL_D:    wang_in[3] = signed'(csr_wdata[15:0]);
            default: ;
         endcase
      end

      unique case (st_ff)
         S_IDLE: begin
            if (cmd_acc) begin
               tgt_vx_in = signed'(req_tdata[23:0]);
               tgt_vy_in = signed'(req_tdata[47:24]);
               tgt_vr_in = signed'(req_tdata[71:48]);
               age_in    = '0;
            end else if (tick_acc) begin
               if (stale) begin
                  tgt_vx_in = '0; tgt_vy_in = '0; tgt_vr_in = '0;
               end
               age_in = age_sum[16] ? AGE_MAX : age_sum[15:0];
               dt_in  = req_tdata[87:72];
               dvx_in = stale ? '0 : 26'(tgt_vx_ff);
               dvy_in = stale ? '0 : 26'(tgt_vy_ff);
               lim_in = max_speed_ff;
               ph_in  = 1'b0;
               k_in   = '0;
               pc_in  = ST_SQ_X;
               st_in  = S_LOAD;
            end
         end
         S_LOAD: begin
            cnt_in = '0;
            st_in  = (op == OP_NONE) ? S_WB : S_BUSY;
            case (op)
               OP_MUL: begin
                  ma_in = 68'(mul_a); mb_in = mul_b; mp_in = '0;
               end
               OP_DIV: begin
                  dnum_in = acc_ff[47:0]; drem_in = '0;
               end
               OP_SQRT: begin
                  snum_in = acc_ff[51:0]; srem_in = '0; sroot_in = '0;
               end
               OP_CORDIC: begin
                  cx_in  = GAIN_Q30;
                  cy_in  = '0;
                  cz_in  = signed'({ang_adj, 16'd0}) >>> 0;
                  cz_in  = 33'(signed'({ang_adj, 16'd0}));
                  cqp_in = (cor_ang > 16'sd16384);
                  cqn_in = (cor_ang < -16'sd16384);
               end
               default: ;
            endcase
         end
         S_BUSY: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == last_cnt) st_in = S_WB;
            case (op)
               OP_MUL: begin
                  if (mb_ff[0]) mp_in = (cnt_ff == 6'd25) ? mp_ff - ma_ff : mp_ff + ma_ff;
                  ma_in = ma_ff <<< 1;
                  mb_in = mb_ff >>> 1;
               end
               OP_DIV: begin
                  drem_in = dge ? 26'(drsh - {1'b0, r_ff}) : drsh[25:0];
                  dnum_in = {dnum_ff[46:0], dge};
               end
               OP_SQRT: begin
                  srem_in  = sge ? 27'(srsh - strial) : srsh[26:0];
                  sroot_in = {sroot_ff[24:0], sge};
                  snum_in  = {snum_ff[49:0], 2'b00};
               end
               OP_CORDIC: begin
                  if (!cz_ff[32]) begin
                     cx_in = cx_ff - cys; cy_in = cy_ff + cxs; cz_in = cz_ff - cat;
                  end else begin
                     cx_in = cx_ff + cys; cy_in = cy_ff - cxs; cz_in = cz_ff + cat;
                  end
               end
               default: ;
            endcase
         end
         S_WB: begin
            st_in = S_LOAD;
            unique case (pc_ff)
               ST_SQ_X: begin acc_in = mp_ff; pc_in = ST_SQ_Y; end
               ST_SQ_Y: begin acc_in = sum_add; pc_in = ST_SQ_L; end
               ST_SQ_L, ST_DIV_Y: begin
                  if (pc_ff == ST_DIV_Y) dvy_in = dvy_ff[25] ? -qs : qs;
                  if (pc_ff == ST_SQ_L && acc_ff > mp_ff) begin
                     pc_in = ST_ROOT;
                  end else if (!ph_ff) begin
                     pc_in = ST_MA;
                  end else begin
                     bvx_in = 24'(bvx_ff + (pc_ff == ST_DIV_Y ? dvx_ff : dvx_ff));
                     bvy_in = 24'(bvy_ff + (pc_ff == ST_DIV_Y ? (dvy_ff[25] ? -qs : qs)
                                                              : dvy_ff));
                     pc_in  = ST_MRA;
                  end
               end
               ST_ROOT:  begin r_in = sroot_ff + {25'd0, (srem_ff != '0)}; pc_in = ST_MUL_X; end
               ST_MUL_X: begin acc_in = mp_ff; pc_in = ST_DIV_X; end
               ST_DIV_X: begin dvx_in = dvx_ff[25] ? -qs : qs; pc_in = ST_MUL_Y; end
               ST_MUL_Y: begin acc_in = mp_ff; pc_in = ST_DIV_Y; end
               ST_MA: begin
                  lim_in = mp_ff[38:16];
                  dvx_in = dvx_ff - 26'(bvx_ff);
                  dvy_in = dvy_ff - 26'(bvy_ff);
                  ph_in  = 1'b1;
                  pc_in  = ST_SQ_X;
               end
               ST_MRA: begin
                  lim_in = mp_ff[38:16];
                  er_in  = 26'(drc) - 26'(bvr_ff);
                  pc_in  = ST_VR;
               end
               ST_VR:   begin bvr_in = 24'(26'(bvr_ff) + erc); pc_in = ST_HROT; end
               ST_HROT: begin c_in = cor_c; s_in = cor_s; pc_in = ST_RX1; end
               ST_RX1:  begin acc_in = mp_ff; pc_in = ST_RX2; end
               ST_RX2:  begin wvx_in = 26'(rnd_sub30); pc_in = ST_RY1; end
               ST_RY1:  begin acc_in = mp_ff; pc_in = ST_RY2; end
               ST_RY2:  begin wvy_in = 26'(rnd_add30); pc_in = ST_PX; end
               ST_PX, ST_PY: begin
                  if (pc_ff == ST_PX) begin
                     posx_in = (pos_t > 34'sd2147483647) ? 32'sh7FFFFFFF :
                               ((pos_t < -34'sd2147483648) ? 32'sh80000000 : 32'(pos_t));
                     pc_in   = ST_PY;
                  end else begin
                     posy_in = (pos_t > 34'sd2147483647) ? 32'sh7FFFFFFF :
                               ((pos_t < -34'sd2147483648) ? 32'sh80000000 : 32'(pos_t));
                     pc_in   = ST_PH;
                  end
               end
               ST_PH:   begin hdg_in = hdg_ff + 16'(p16); pc_in = ST_SPIN; end
               ST_SPIN: begin spin_in = 34'(p32); pc_in = ST_WROT; end
               ST_WROT: begin c_in = cor_c; s_in = cor_s; pc_in = ST_W1; end
               ST_W1:   begin acc_in = mp_ff; pc_in = ST_W2; end
               ST_W2: begin
                  wspd_in[k_ff] = whl_sat;
                  k_in  = k_ff + 2'd1;
                  pc_in = ST_WROT;
                  if (k_ff == 2'd3) st_in = S_FIN;
               end
               default: st_in = S_FIN;
            endcase
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'd0, wspd_ff[3], wspd_ff[2], wspd_ff[1], wspd_ff[0],
                               bvr_ff, bvy_ff, bvx_ff, hdg_ff, posy_ff, posx_ff};
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff  <= RST_MAX_SPEED;
         max_accel_ff  <= RST_MAX_ACCEL;
         max_turn_ff   <= RST_MAX_TURN;
         turn_accel_ff <= RST_TURN_ACCEL;
         wang_ff[0] <= signed'(RST_WHEEL_A);
         wang_ff[1] <= signed'(RST_WHEEL_B);
         wang_ff[2] <= signed'(RST_WHEEL_C);
         wang_ff[3] <= signed'(RST_WHEEL_D);
         tgt_vx_ff <= '0; tgt_vy_ff <= '0; tgt_vr_ff <= '0;
         age_ff <= '0;
         bvx_ff <= '0; bvy_ff <= '0; bvr_ff <= '0;
         posx_ff <= '0; posy_ff <= '0; hdg_ff <= '0;
         st_ff <= S_IDLE; pc_ff <= ST_SQ_X; cnt_ff <= '0; ph_ff <= 1'b0; k_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         max_speed_ff  <= max_speed_in;
         max_accel_ff  <= max_accel_in;
         max_turn_ff   <= max_turn_in;
         turn_accel_ff <= turn_accel_in;
         wang_ff <= wang_in;
         tgt_vx_ff <= tgt_vx_in; tgt_vy_ff <= tgt_vy_in; tgt_vr_ff <= tgt_vr_in;
         age_ff <= age_in;
         bvx_ff <= bvx_in; bvy_ff <= bvy_in; bvr_ff <= bvr_in;
         posx_ff <= posx_in; posy_ff <= posy_in; hdg_ff <= hdg_in;
         st_ff <= st_in; pc_ff <= pc_in; cnt_ff <= cnt_in; ph_ff <= ph_in; k_ff <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff <= dt_in; dvx_ff <= dvx_in; dvy_ff <= dvy_in; lim_ff <= lim_in;
      acc_ff <= acc_in; r_ff <= r_in; c_ff <= c_in; s_ff <= s_in; er_ff <= er_in;
      wvx_ff <= wvx_in; wvy_ff <= wvy_in; spin_ff <= spin_in; wspd_ff <= wspd_in;
      ma_ff <= ma_in; mp_ff <= mp_in; mb_ff <= mb_in;
      dnum_ff <= dnum_in; drem_ff <= drem_in;
      snum_ff <= snum_in; srem_ff <= srem_in; sroot_ff <= sroot_in;
      cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; cqp_ff <= cqp_in; cqn_ff <= cqn_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      tick_acc |=> (st_ff == S_LOAD && pc_ff == ST_SQ_X))
      else $error("tick did not start the step sequence");

   a_cmd_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (cmd_acc && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("command produced a result");

   a_age_mono: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(cmd_acc)) |-> (age_ff >= $past(age_ff)))
      else $error("command age went backward without a command");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(st_ff == S_FIN))
      else $error("result raised outside the finish step");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for omni_base_motion_integrator: drives commands and
// ticks over the req stream, predicts pose, velocity and wheel speeds in
// fixed point and checks every rsp transfer. Depends on obmi_pkg.
`timescale 1ns / 1ps

module testbench;
   import obmi_pkg::*;

   localparam int  STALL_LIMIT = 20000;
   localparam int  SETTLE      = 1200;
   localparam longint TWO_PI_Q16 = 411775;

   typedef struct {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [15:0] heading;
      logic signed [23:0] vel_x;
      logic signed [23:0] vel_y;
      logic signed [23:0] turn;
      logic signed [24:0] wheel [4];
   } motion_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [87:0]  req_tdata = '0;    // cmd_vx, cmd_vy, cmd_vr, step_time
   logic         req_tuser = 1'b0;  // kind
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [255:0] rsp_tdata;         // pos_x, pos_y, heading_out, vel_x_out,
                                    // vel_y_out, turn_rate_out, wheel_speed_a..d
   logic         csr_we = 1'b0;
   logic [2:0]   csr_addr = '0;
   logic [22:0]  csr_wdata = '0;

   omni_base_motion_integrator i_dut (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata,
      .csr_we, .csr_addr, .csr_wdata
   );

   // predictor state
   logic [22:0]        lim_speed, lim_accel, lim_turn, lim_turn_accel;
   logic signed [15:0] wheel_dir [4];
   logic signed [23:0] tgt_vx, tgt_vy, tgt_vr;
   logic [15:0]        cmd_age;
   logic signed [23:0] vel_x, vel_y, vel_r;
   logic signed [31:0] world_x, world_y;
   logic signed [15:0] heading;

   motion_t pending_motion [$];
   int      errors = 0;
   int      items_sent = 0;
   bit      no_idle = 1'b0;
   bit      hold_rsp = 1'b0;
   int      quiet_cycles = 0;

   longint atan_turn [24] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
      64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
      64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};

   initial forever #6 clock = ~clock;

   function automatic longint round_shift(longint v, int n);
      return (v + (longint'(1) <<< (n - 1))) >>> n;
   endfunction

   function automatic longint clip(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint unsigned root_up(longint unsigned n);
      longint unsigned r, b, x;
      r = 0;
      b = 64'd1 << 62;
      x = n;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      if (r * r < n) r++;
      return r;
   endfunction

   function automatic longint shrink(longint v, longint unsigned lim,
                                     longint unsigned d);
      longint unsigned mag;
      longint q;
      mag = v < 0 ? -v : v;
      q = longint'(mag * lim / d);
      return v < 0 ? -q : q;
   endfunction

   function automatic void sin_cos(input longint ang, output longint c,
                                   output longint s);
      int     quad;
      longint x, y, z, t, a;
      quad = 0;
      a = ang;
      x = 652032875;
      y = 0;
      if (a > 16384) begin
         a -= 16384; quad = 1;
      end else if (a < -16384) begin
         a += 16384; quad = -1;
      end
      z = a * 65536;
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
         if (z >= 0) begin
            t = x - (y >>> i);
            y = y + (x >>> i);
            z -= atan_turn[i];
         end else begin
            t = x + (y >>> i);
            y = y - (x >>> i);
            z += atan_turn[i];
         end
         x = t;
      end
      if (quad == 1) begin
         c = -y; s = x;
      end else if (quad == -1) begin
         c = y; s = -x;
      end else begin
         c = x; s = y;
      end
   endfunction

   function automatic void base_reset();
      lim_speed = RST_MAX_SPEED;
      lim_accel = RST_MAX_ACCEL;
      lim_turn = RST_MAX_TURN;
      lim_turn_accel = RST_TURN_ACCEL;
      wheel_dir[0] = RST_WHEEL_A;
      wheel_dir[1] = RST_WHEEL_B;
      wheel_dir[2] = RST_WHEEL_C;
      wheel_dir[3] = RST_WHEEL_D;
      tgt_vx = 0; tgt_vy = 0; tgt_vr = 0; cmd_age = 0;
      vel_x = 0; vel_y = 0; vel_r = 0;
      world_x = 0; world_y = 0; heading = 0;
   endfunction

   // advance the motion model for one accepted item
   function automatic void integrate(bit kind, logic [87:0] d);
      longint dt, age, vx, vy, ex, ey, dr, er, c, s, wx, wy, spin, hd;
      longint unsigned n2, ma, mra, r;
      motion_t m;
      if (!kind) begin
         tgt_vx = d[23:0];
         tgt_vy = d[47:24];
         tgt_vr = d[71:48];
         cmd_age = 0;
         return;
      end
      dt = d[87:72];
      if (cmd_age > AGE_LIMIT) begin
         tgt_vx = 0; tgt_vy = 0; tgt_vr = 0;
      end
      age = longint'(cmd_age) + dt;
      cmd_age = age > 65535 ? 16'hFFFF : age[15:0];

      vx = tgt_vx;
      vy = tgt_vy;
      n2 = vx * vx + vy * vy;
      if (n2 > longint'(lim_speed) * longint'(lim_speed)) begin
         r = root_up(n2);
         vx = shrink(vx, lim_speed, r);
         vy = shrink(vy, lim_speed, r);
      end
      ex = vx - vel_x;
      ey = vy - vel_y;
      ma = (longint'(lim_accel) * dt) >> 16;
      n2 = ex * ex + ey * ey;
      if (n2 > ma * ma) begin
         r = root_up(n2);
         ex = shrink(ex, ma, r);
         ey = shrink(ey, ma, r);
      end
      vel_x = vel_x + ex;
      vel_y = vel_y + ey;

      dr = tgt_vr;
      if (dr > longint'(lim_turn)) dr = lim_turn;
      if (dr < -longint'(lim_turn)) dr = -longint'(lim_turn);
      er = dr - vel_r;
      mra = (longint'(lim_turn_accel) * dt) >> 16;
      if (er > longint'(mra)) er = mra;
      else if (er < -longint'(mra)) er = -longint'(mra);
      vel_r = vel_r + er;

      sin_cos(heading, c, s);
      wx = round_shift(c * vel_x - s * vel_y, 30);
      wy = round_shift(s * vel_x + c * vel_y, 30);
      world_x = clip(world_x + round_shift(wx * dt, 16), 32);
      world_y = clip(world_y + round_shift(wy * dt, 16), 32);
      hd = heading + round_shift(vel_r * dt, 16);
      heading = hd[15:0];

      m.pos_x = world_x;
      m.pos_y = world_y;
      m.heading = heading;
      m.vel_x = vel_x;
      m.vel_y = vel_y;
      m.turn = vel_r;
      spin = round_shift(longint'(BASE_RADIUS) * vel_r * TWO_PI_Q16, 32);
      for (int k = 0; k < 4; k++) begin
         sin_cos(wheel_dir[k], c, s);
         m.wheel[k] = clip(round_shift(c * vel_x + s * vel_y, 30) + spin, 25);
      end
      pending_motion.push_back(m);
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 150);
   endfunction

   // receiver
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
         end else if (stall > 0) begin
            stall--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = 1'b1;
            stall = pick_gap();
         end
      end
   end

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         $error("%s expected %0d actual %0d", name, want, got);
      end
   endtask

   always @(posedge clock) begin
      motion_t m;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_motion.size() == 0) begin
            errors++;
            $error("result transfer with nothing expected");
         end else begin
            m = pending_motion.pop_front();
            check_field("pos_x", m.pos_x, $signed(rsp_tdata[31:0]));
            check_field("pos_y", m.pos_y, $signed(rsp_tdata[63:32]));
            check_field("heading_out", m.heading, $signed(rsp_tdata[79:64]));
            check_field("vel_x_out", m.vel_x, $signed(rsp_tdata[103:80]));
            check_field("vel_y_out", m.vel_y, $signed(rsp_tdata[127:104]));
            check_field("turn_rate_out", m.turn, $signed(rsp_tdata[151:128]));
            check_field("wheel_speed_a", m.wheel[0], $signed(rsp_tdata[176:152]));
            check_field("wheel_speed_b", m.wheel[1], $signed(rsp_tdata[201:177]));
            check_field("wheel_speed_c", m.wheel[2], $signed(rsp_tdata[226:202]));
            check_field("wheel_speed_d", m.wheel[3], $signed(rsp_tdata[251:227]));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_item(bit kind, logic [87:0] d);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = d;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      integrate(kind, d);
      items_sent++;
   endtask

   task automatic send_cmd(logic [23:0] vx, logic [23:0] vy, logic [23:0] vr);
      send_item(1'b0, {16'($urandom), vr, vy, vx});
   endtask

   task automatic send_tick(logic [15:0] dt);
      send_item(1'b1, {dt, 24'($urandom), 24'($urandom), 24'($urandom)});
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_motion.size() != 0) @(negedge clock);
   endtask

   task automatic settle();
      drain();
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [22:0] v);
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = v;
      case (idx)
         CSR_MAX_SPEED:  lim_speed = v;
         CSR_MAX_ACCEL:  lim_accel = v;
         CSR_MAX_TURN:   lim_turn = v;
         CSR_TURN_ACCEL: lim_turn_accel = v;
         CSR_WHEEL_A:    wheel_dir[0] = v[15:0];
         CSR_WHEEL_B:    wheel_dir[1] = v[15:0];
         CSR_WHEEL_C:    wheel_dir[2] = v[15:0];
         CSR_WHEEL_D:    wheel_dir[3] = v[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_limits(logic [22:0] sp, logic [22:0] ac, logic [22:0] tr,
                             logic [22:0] ta);
      settle();
      write_reg(CSR_MAX_SPEED, sp);
      write_reg(CSR_MAX_ACCEL, ac);
      write_reg(CSR_MAX_TURN, tr);
      write_reg(CSR_TURN_ACCEL, ta);
   endtask

   task automatic set_wheels(logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic [15:0] d);
      settle();
      write_reg(CSR_WHEEL_A, 23'(a));
      write_reg(CSR_WHEEL_B, 23'(b));
      write_reg(CSR_WHEEL_C, 23'(c));
      write_reg(CSR_WHEEL_D, 23'(d));
   endtask

   function automatic logic [23:0] rand_speed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 3))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            default: return 24'hFFFFFF;
         endcase
      end
      if (r < 50) return 24'($urandom);
      return 24'($signed($urandom_range(0, 400000)) - 200000);
   endfunction

   function automatic logic [15:0] rand_dt();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 3000));
      if (r < 85) return 16'($urandom);
      case ($urandom_range(0, 3))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return AGE_LIMIT;
         default: return AGE_LIMIT + 16'd1;
      endcase
   endfunction

   function automatic logic [22:0] rand_limit();
      case ($urandom_range(0, 5))
         0: return 23'd0;
         1: return 23'h7FFFFF;
         2: return 23'($urandom);
         default: return 23'($urandom_range(1, 400000));
      endcase
   endfunction

   function automatic logic [15:0] rand_angle();
      case ($urandom_range(0, 4))
         0: return 16'h4000;
         1: return 16'hC000;
         2: return 16'h4001;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic test_field_extremes();
      send_cmd(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_tick(16'hFFFF);
      send_cmd(24'h800000, 24'h800000, 24'h800000);
      send_tick(16'd0);
      send_tick(16'd1);
      send_cmd(24'h555555, 24'hAAAAAA, 24'h000000);
      send_tick(16'h5555);
      send_tick(16'hAAAA);
   endtask

   task automatic test_stale_and_age();
      send_cmd(24'd50000, -24'sd30000, 24'd9000);
      send_tick(AGE_LIMIT);
      send_tick(16'd1);
      send_tick(16'd100);
      send_tick(16'hFFFF);
      send_tick(16'hFFFF);
   endtask

   task automatic test_zero_limits();
      set_limits(23'd0, 23'd0, 23'd0, 23'd0);
      send_cmd(24'd70000, 24'd70000, 24'd20000);
      send_tick(16'd2000);
      send_tick(16'hFFFF);
      set_limits(RST_MAX_SPEED, RST_MAX_ACCEL, RST_MAX_TURN, RST_TURN_ACCEL);
   endtask

   task automatic test_turn_and_wrap();
      set_limits(23'h7FFFFF, 23'h7FFFFF, 23'd40000, 23'h7FFFFF);
      send_cmd(24'd0, 24'd0, 24'h800000);
      send_tick(16'd3000);
      send_tick(16'd3000);
      set_limits(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF);
      send_cmd(24'd1000, 24'd0, 24'h7FFFFF);
      send_tick(16'hFFFF);
      send_cmd(24'd1000, 24'd0, 24'h7FFFFF);
      send_tick(16'hFFFF);
   endtask

   task automatic test_wheel_saturation();
      set_wheels(16'h2000, 16'h6000, 16'hA000, 16'h4001);
      send_cmd(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_tick(16'hFFFF);
      send_cmd(24'h800000, 24'h800000, 24'h800000);
      send_tick(16'hFFFF);
   endtask

   task automatic test_position_saturation();
      set_limits(23'h7FFFFF, 23'h7FFFFF, 23'd0, 23'h7FFFFF);
      set_wheels(RST_WHEEL_A, RST_WHEEL_B, RST_WHEEL_C, RST_WHEEL_D);
      no_idle = 1'b1;
      repeat (270) begin
         send_cmd(24'h7FFFFF, 24'd0, 24'd0);
         send_tick(16'hFFFF);
      end
      no_idle = 1'b0;
      send_cmd(24'h800000, 24'd0, 24'd0);
      send_tick(16'hFFFF);
   endtask

   task automatic test_backpressure();
      set_limits(23'd300000, 23'd500000, 23'd20000, 23'd80000);
      drain();
      fork
         begin
            hold_rsp = 1'b1;
            repeat (4000) @(negedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      send_cmd(24'd90000, 24'd20000, 24'd5000);
      repeat (6) send_tick(16'd700);
      drain();
   endtask

   task automatic test_random_motion();
      int start;
      for (int phase = 0; phase < 3; phase++) begin
         settle();
         for (int k = 0; k < 4; k++)
            write_reg(csr_index_type'(k), rand_limit());
         for (int k = 4; k < 8; k++)
            write_reg(csr_index_type'(k), 23'(rand_angle()));
         start = items_sent;
         while (items_sent - start < 150) begin
            no_idle = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 75) begin
               send_cmd(rand_speed(), rand_speed(), rand_speed());
               repeat ($urandom_range(1, 4)) send_tick(rand_dt());
            end else if ($urandom_range(0, 1)) begin
               send_tick(16'($urandom));
            end else begin
               send_cmd(rand_speed(), rand_speed(), rand_speed());
            end
         end
         no_idle = 1'b0;
      end
   endtask

   initial begin
      base_reset();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_field_extremes();
      test_stale_and_age();
      test_zero_limits();
      test_turn_and_wrap();
      test_wheel_saturation();
      test_backpressure();
      test_position_saturation();
      test_random_motion();
      settle();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/obmi_pkg.sv
rtl/omni_base_motion_integrator.sv
bench/testbench.sv
